### hdl/dsp_pkg.sv
`timescale 1ns / 1ps

package dsp_pkg;

   // Size limits of a signature buffer in bytes
   localparam int MIN_SIG_BYTES = 8;
   localparam int MAX_SIG_BYTES = 72;

   // Byte position saturates here
   localparam logic [6:0] POS_MAX = 7'd127;

   // Width of position and length sums (up to 6 + 255 + 255)
   localparam int SPAN_W = 10;

   // DER tags
   localparam logic [7:0] SEQ_TAG = 8'h30;
   localparam logic [7:0] INT_TAG = 8'h02;

   // Length of S that needs the byte-wise comparison against half order
   localparam logic [7:0] S_FULL_BYTES = 8'd32;

   // Byte roles
   localparam logic [1:0] ROLE_HDR   = 2'd0;
   localparam logic [1:0] ROLE_R     = 2'd1;
   localparam logic [1:0] ROLE_S     = 2'd2;
   localparam logic [1:0] ROLE_TRAIL = 2'd3;

   // Running comparison of S against half the group order
   localparam logic [1:0] CMP_EQUAL   = 2'd0;
   localparam logic [1:0] CMP_LESS    = 2'd1;
   localparam logic [1:0] CMP_GREATER = 2'd2;

   // Verdict codes
   localparam logic [3:0] ERR_OK        = 4'd0;
   localparam logic [3:0] ERR_SIZE      = 4'd1;
   localparam logic [3:0] ERR_SEQ_TAG   = 4'd2;
   localparam logic [3:0] ERR_TOTAL_LEN = 4'd3;
   localparam logic [3:0] ERR_R_TAG     = 4'd4;
   localparam logic [3:0] ERR_R_LEN     = 4'd5;
   localparam logic [3:0] ERR_R_NEG     = 4'd6;
   localparam logic [3:0] ERR_R_PAD     = 4'd7;
   localparam logic [3:0] ERR_S_TAG     = 4'd8;
   localparam logic [3:0] ERR_S_LEN     = 4'd9;
   localparam logic [3:0] ERR_S_NEG     = 4'd10;
   localparam logic [3:0] ERR_S_PAD     = 4'd11;
   localparam logic [3:0] ERR_HIGH_S    = 4'd12;

   // Control register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DER_EXACT     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRE_LOW_S = 1'd1;

   // Raw check outcomes of one byte, valid when it is the last one
   typedef struct packed {
      logic size_bad;
      logic seq_bad;
      logic len_ne;
      logic len_gt;
      logic r_tag_bad;
      logic r_len_bad;
      logic r_neg;
      logic r_pad;
      logic s_tag_bad;
      logic s_len_bad;
      logic s_neg;
      logic s_pad;
      logic s_high;
   } check_type;

   // Classified byte passed from front to back
   typedef struct packed {
      logic [1:0] role;
      logic [7:0] value;
      logic       last;
      check_type  chk;
   } item_type;

   // Half of the secp256k1 group order, most significant byte first
   function automatic logic [7:0] half_order_byte(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = 8'h7F;
         5'd16:   b = 8'h5D;
         5'd17:   b = 8'h57;
         5'd18:   b = 8'h6E;
         5'd19:   b = 8'h73;
         5'd20:   b = 8'h57;
         5'd21:   b = 8'hA4;
         5'd22:   b = 8'h50;
         5'd23:   b = 8'h1D;
         5'd24:   b = 8'hDF;
         5'd25:   b = 8'hE9;
         5'd26:   b = 8'h2F;
         5'd27:   b = 8'h46;
         5'd28:   b = 8'h68;
         5'd29:   b = 8'h1B;
         5'd30:   b = 8'h20;
         5'd31:   b = 8'hA0;
         default: b = 8'hFF;
      endcase
      return b;
   endfunction

endpackage

### hdl/dsp_front.sv
`timescale 1ns / 1ps

module dsp_front
   import dsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] sig_byte,
   input  logic       last,
   output item_type   item
);

   logic [6:0]        position_ff;
   logic [7:0]        total_len_ff, total_len_in;
   logic [7:0]        r_len_ff, r_len_in;
   logic [7:0]        s_len_ff, s_len_in;
   logic              lead_zero_ff, lead_zero_in;
   logic [1:0]        s_cmp_ff, s_cmp_in;
   logic              seq_ok_ff, seq_ok_in;
   logic              r_tag_ok_ff, r_tag_ok_in;
   logic              s_tag_ok_ff, s_tag_ok_in;
   logic              r_neg_ff, r_neg_in;
   logic              r_pad_ff, r_pad_in;
   logic              s_neg_ff, s_neg_in;
   logic              s_pad_ff, s_pad_in;

   logic [SPAN_W-1:0] pos_w, r_w, s_w, end_w, off_w, size_w, end_in_w, r_in_w, s_in_w;
   logic [7:0]        half_byte;
   logic [1:0]        role;

   // Widen position and lengths for the boundary compares
   assign pos_w  = SPAN_W'(position_ff);
   assign r_w    = SPAN_W'(r_len_ff);
   assign s_w    = SPAN_W'(s_len_ff);
   assign end_w  = SPAN_W'(total_len_ff) + SPAN_W'(2);
   assign off_w  = pos_w - r_w - SPAN_W'(6);
   assign half_byte = half_order_byte(off_w[4:0]);

   // Tag the byte by where it falls in the structure
   always_comb begin
      if (pos_w < SPAN_W'(2))                    role = ROLE_HDR;
      else if (pos_w >= end_w)                   role = ROLE_TRAIL;
      else if (pos_w < SPAN_W'(4))               role = ROLE_HDR;
      else if (pos_w < r_w + SPAN_W'(4))         role = ROLE_R;
      else if (pos_w < r_w + SPAN_W'(6))         role = ROLE_HDR;
      else if (pos_w < r_w + s_w + SPAN_W'(6))   role = ROLE_S;
      else                                       role = ROLE_TRAIL;
   end

   // Update header fields, sign and padding flags and the low-S compare
   always_comb begin
      seq_ok_in    = seq_ok_ff;
      total_len_in = total_len_ff;
      r_tag_ok_in  = r_tag_ok_ff;
      r_len_in     = r_len_ff;
      s_tag_ok_in  = s_tag_ok_ff;
      s_len_in     = s_len_ff;
      lead_zero_in = lead_zero_ff;
      s_cmp_in     = s_cmp_ff;
      r_neg_in     = r_neg_ff;
      r_pad_in     = r_pad_ff;
      s_neg_in     = s_neg_ff;
      s_pad_in     = s_pad_ff;
      if (pos_w == SPAN_W'(0)) begin
         seq_ok_in = (sig_byte == SEQ_TAG);
      end else if (pos_w == SPAN_W'(1)) begin
         total_len_in = sig_byte;
      end else if (pos_w == SPAN_W'(2)) begin
         r_tag_ok_in = (sig_byte == INT_TAG);
      end else if (pos_w == SPAN_W'(3)) begin
         r_len_in = sig_byte;
      end else begin
         if (pos_w == SPAN_W'(4) && r_len_ff != 8'd0) begin
            r_neg_in     = sig_byte[7];
            lead_zero_in = (sig_byte == 8'd0);
         end
         if (pos_w == SPAN_W'(5) && r_len_ff > 8'd1) begin
            r_pad_in = lead_zero_ff && !sig_byte[7];
         end
         if (pos_w == r_w + SPAN_W'(4)) begin
            s_tag_ok_in = (sig_byte == INT_TAG);
         end
         if (pos_w == r_w + SPAN_W'(5)) begin
            s_len_in = sig_byte;
            if (sig_byte < S_FULL_BYTES)      s_cmp_in = CMP_LESS;
            else if (sig_byte > S_FULL_BYTES) s_cmp_in = CMP_GREATER;
            else                              s_cmp_in = CMP_EQUAL;
         end
         if (pos_w == r_w + SPAN_W'(6)) begin
            s_neg_in     = sig_byte[7];
            lead_zero_in = (sig_byte == 8'd0);
         end
         if (pos_w == r_w + SPAN_W'(7) && s_len_ff > 8'd1) begin
            s_pad_in = lead_zero_ff && !sig_byte[7];
         end
         // settle the compare at the first differing byte of a full-width S
         if (s_len_ff == S_FULL_BYTES && s_cmp_ff == CMP_EQUAL &&
             pos_w >= r_w + SPAN_W'(6) &&
             pos_w < r_w + SPAN_W'(6) + SPAN_W'(S_FULL_BYTES)) begin
            if (sig_byte < half_byte)      s_cmp_in = CMP_LESS;
            else if (sig_byte > half_byte) s_cmp_in = CMP_GREATER;
         end
      end
   end

   // Evaluate every check against the state including this byte
   assign size_w   = pos_w + SPAN_W'(1);
   assign end_in_w = SPAN_W'(total_len_in) + SPAN_W'(2);
   assign r_in_w   = SPAN_W'(r_len_in);
   assign s_in_w   = SPAN_W'(s_len_in);

   always_comb begin
      item.role          = role;
      item.value         = sig_byte;
      item.last          = last;
      item.chk.size_bad  = (size_w < SPAN_W'(MIN_SIG_BYTES)) ||
                           (size_w > SPAN_W'(MAX_SIG_BYTES));
      item.chk.seq_bad   = !seq_ok_in;
      item.chk.len_ne    = (end_in_w != size_w);
      item.chk.len_gt    = (end_in_w > size_w);
      item.chk.r_tag_bad = !r_tag_ok_in;
      item.chk.r_len_bad = (r_len_in == 8'd0) || (r_in_w + SPAN_W'(4) >= end_in_w);
      item.chk.r_neg     = r_neg_in;
      item.chk.r_pad     = r_pad_in;
      item.chk.s_tag_bad = !s_tag_ok_in;
      item.chk.s_len_bad = (s_len_in == 8'd0) ||
                           (r_in_w + s_in_w + SPAN_W'(6) != end_in_w);
      item.chk.s_neg     = s_neg_in;
      item.chk.s_pad     = s_pad_in;
      item.chk.s_high    = (s_cmp_in == CMP_GREATER);
   end

   // Advance on each transaction, clear after the last byte
   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         position_ff  <= '0;
         total_len_ff <= '0;
         r_len_ff     <= '0;
         s_len_ff     <= '0;
         lead_zero_ff <= 1'b0;
         s_cmp_ff     <= CMP_EQUAL;
         seq_ok_ff    <= 1'b0;
         r_tag_ok_ff  <= 1'b0;
         s_tag_ok_ff  <= 1'b0;
         r_neg_ff     <= 1'b0;
         r_pad_ff     <= 1'b0;
         s_neg_ff     <= 1'b0;
         s_pad_ff     <= 1'b0;
      end else if (accept) begin
         if (position_ff != POS_MAX) begin
            position_ff <= position_ff + 7'd1;
         end
         total_len_ff <= total_len_in;
         r_len_ff     <= r_len_in;
         s_len_ff     <= s_len_in;
         lead_zero_ff <= lead_zero_in;
         s_cmp_ff     <= s_cmp_in;
         seq_ok_ff    <= seq_ok_in;
         r_tag_ok_ff  <= r_tag_ok_in;
         s_tag_ok_ff  <= s_tag_ok_in;
         r_neg_ff     <= r_neg_in;
         r_pad_ff     <= r_pad_in;
         s_neg_ff     <= s_neg_in;
         s_pad_ff     <= s_pad_in;
      end
   end

endmodule

### hdl/dsp_queue.sv
`timescale 1ns / 1ps

module dsp_queue
   import dsp_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   // Hold pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (!push && pop) count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Store the incoming item
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

### hdl/dsp_back.sv
`timescale 1ns / 1ps

module dsp_back
   import dsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        der_exact,
   input  logic        require_low_s,
   input  logic        head_valid,
   input  item_type    head_item,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic       rsp_valid_ff;
   logic [1:0] role_ff;
   logic [7:0] value_ff;
   logic       last_ff;
   logic       ok_ff;
   logic [3:0] err_ff;
   logic [3:0] err_in;
   check_type  chk;

   assign chk = head_item.chk;

   // Pick the first failing check in priority order
   always_comb begin
      if (chk.size_bad)                          err_in = ERR_SIZE;
      else if (chk.seq_bad)                      err_in = ERR_SEQ_TAG;
      else if (der_exact ? chk.len_ne : chk.len_gt) err_in = ERR_TOTAL_LEN;
      else if (chk.r_tag_bad)                    err_in = ERR_R_TAG;
      else if (chk.r_len_bad)                    err_in = ERR_R_LEN;
      else if (der_exact && chk.r_neg)           err_in = ERR_R_NEG;
      else if (der_exact && chk.r_pad)           err_in = ERR_R_PAD;
      else if (chk.s_tag_bad)                    err_in = ERR_S_TAG;
      else if (chk.s_len_bad)                    err_in = ERR_S_LEN;
      else if (der_exact && chk.s_neg)           err_in = ERR_S_NEG;
      else if (der_exact && chk.s_pad)           err_in = ERR_S_PAD;
      else if (require_low_s && chk.s_high)      err_in = ERR_HIGH_S;
      else                                       err_in = ERR_OK;
   end

   // Load the output register when it is empty or being drained
   assign pop = head_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         role_ff  <= head_item.role;
         value_ff <= head_item.value;
         last_ff  <= head_item.last;
         ok_ff    <= head_item.last && (err_in == ERR_OK);
         err_ff   <= head_item.last ? err_in : ERR_OK;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, err_ff, ok_ff, value_ff};
   assign rsp_tuser  = role_ff;
   assign rsp_tlast  = last_ff;

endmodule

### hdl/der_signature_parse_low_s.sv
`timescale 1ns / 1ps

// Channel   Direction  Transaction         tdata / tuser / tlast
// req_      in         one signature byte  tdata[7:0] byte; tlast last byte
// rsp_      out        one tagged byte     tdata[7:0] byte, [8] valid, [12:9] error;
//                                          tuser[1:0] role; tlast verdict present
// csr_      in         register write      csr_addr index, csr_wdata value
//
// One byte per cycle sustained while rsp_ is not stalled; a taken byte goes
// from front classification into the queue, then into the verdict register.
// The throughput is set by the front, which updates the per-signature state
// once per byte. Reset is synchronous, active high; both control registers
// come out of reset at 1. A stall on rsp_ fills the queue and only then
// drops req_tready.

module der_signature_parse_low_s
   import dsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] sig_byte
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [7:0] value, [8] valid_res, [12:9] error_code
   output logic [1:0]           rsp_tuser,   // [1:0] byte_role
   output logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic                 csr_wdata
);

   logic     der_exact_ff;
   logic     require_low_s_ff;
   logic     accept;
   logic     queue_full;
   logic     head_valid;
   logic     pop;
   item_type front_item;
   item_type head_item;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         der_exact_ff     <= 1'b1;
         require_low_s_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DER_EXACT:     der_exact_ff     <= csr_wdata;
            CSR_REQUIRE_LOW_S: require_low_s_ff <= csr_wdata;
         endcase
      end
   end

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   dsp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .sig_byte (req_tdata),
      .last     (req_tlast),
      .item     (front_item)
   );

   dsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_item  (front_item),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   dsp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .der_exact     (der_exact_ff),
      .require_low_s (require_low_s_ff),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

   // Verdict flag agrees with the error code on the last byte
   a_verdict_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[8] == (rsp_tdata[12:9] == ERR_OK)))
      else $error("valid_res disagrees with error_code");

   // Verdict fields stay clear on bytes before the last
   a_no_verdict_midway: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[12:8] == 5'd0))
      else $error("verdict fields set on a non-final byte");

   // Error code stays within the defined codes
   a_error_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:9] <= ERR_HIGH_S))
      else $error("error_code out of range");

   // A byte taken into an empty path shows up after the queue and verdict register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept && !head_valid && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("accepted byte did not reach the output");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import dsp_pkg::*;

   // One signature byte as the sender queues it
   typedef struct packed {
      logic [7:0] sig_byte;
      logic       last;
   } sig_item_type;

   // One tagged byte as the block should return it
   typedef struct packed {
      logic [1:0] role;
      logic [7:0] value;
      logic       done;
      logic       ok;
      logic [3:0] err;
   } tagged_byte_type;

   // Ways a well-formed signature gets broken
   typedef enum int {
      FLAW_SEQ_TAG, FLAW_TOTAL_LEN, FLAW_R_TAG, FLAW_R_LEN, FLAW_R_NEG, FLAW_R_PAD,
      FLAW_S_TAG, FLAW_S_LEN, FLAW_S_NEG, FLAW_S_PAD, FLAW_TRAILING, FLAW_TRUNCATE,
      FLAW_HIGH_S, FLAW_COUNT
   } flaw_type;

   // Receiver back-pressure patterns
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_type;

   // Half the secp256k1 group order, most significant byte in the top bits
   localparam logic [255:0] HALF_N =
      256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_5D576E73_57A4501D_DFE92F46_681B20A0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;  // [7:0] sig_byte
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;       // [7:0] value, [8] valid_res, [12:9] error_code
   logic [1:0]           rsp_tuser;       // [1:0] byte_role
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic                 csr_wdata = 1'b0;

   der_signature_parse_low_s u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sig_item_type    sig_byte_q[$];
   tagged_byte_type tagged_byte_q[$];
   logic [7:0]      frame_q[$];

   int mismatch_count = 0;
   int bytes_checked = 0;
   int queued_bytes = 0;
   int verdict_hits[16];

   // Shadow of the control registers
   logic cfg_strict = 1'b1;
   logic cfg_low_s = 1'b1;

   // Shadow of the per-signature parse state
   logic [6:0] trk_pos;
   logic [7:0] trk_total;
   logic [7:0] trk_rlen;
   logic [7:0] trk_slen;
   logic       lead_zero;
   logic [1:0] s_cmp;
   logic       seen_seq_tag, seen_r_tag, seen_s_tag;
   logic       r_is_neg, r_is_padded, s_is_neg, s_is_padded;

   function automatic logic [7:0] half_byte(int k);
      return HALF_N[255 - 8 * k -: 8];
   endfunction

   function automatic void clear_tracker();
      trk_pos = '0;
      trk_total = '0;
      trk_rlen = '0;
      trk_slen = '0;
      lead_zero = 1'b0;
      s_cmp = CMP_EQUAL;
      seen_seq_tag = 1'b0;
      seen_r_tag = 1'b0;
      seen_s_tag = 1'b0;
      r_is_neg = 1'b0;
      r_is_padded = 1'b0;
      s_is_neg = 1'b0;
      s_is_padded = 1'b0;
   endfunction

   // First failing check of a finished signature of the given size
   function automatic logic [3:0] judge_signature(int size);
      int tot_end;
      int r;
      int s;
      tot_end = int'(trk_total) + 2;
      r = trk_rlen;
      s = trk_slen;
      if (size < MIN_SIG_BYTES || size > MAX_SIG_BYTES) return ERR_SIZE;
      if (!seen_seq_tag) return ERR_SEQ_TAG;
      if (cfg_strict ? (tot_end != size) : (tot_end > size)) return ERR_TOTAL_LEN;
      if (!seen_r_tag) return ERR_R_TAG;
      if (r == 0 || 4 + r >= tot_end) return ERR_R_LEN;
      if (cfg_strict && r_is_neg) return ERR_R_NEG;
      if (cfg_strict && r_is_padded) return ERR_R_PAD;
      if (!seen_s_tag) return ERR_S_TAG;
      if (s == 0 || 6 + r + s != tot_end) return ERR_S_LEN;
      if (cfg_strict && s_is_neg) return ERR_S_NEG;
      if (cfg_strict && s_is_padded) return ERR_S_PAD;
      if (cfg_low_s && s_cmp == CMP_GREATER) return ERR_HIGH_S;
      return ERR_OK;
   endfunction

   // Tag one accepted byte and advance the shadow parse state
   function automatic tagged_byte_type track_byte(logic [7:0] b, logic last);
      int p;
      int r;
      int s;
      int tot_end;
      logic [7:0] h;
      tagged_byte_type res;
      p = trk_pos;
      r = trk_rlen;
      s = trk_slen;
      tot_end = int'(trk_total) + 2;

      if (p < 2) res.role = ROLE_HDR;
      else if (p >= tot_end) res.role = ROLE_TRAIL;
      else if (p < 4) res.role = ROLE_HDR;
      else if (p < 4 + r) res.role = ROLE_R;
      else if (p < 6 + r) res.role = ROLE_HDR;
      else if (p < 6 + r + s) res.role = ROLE_S;
      else res.role = ROLE_TRAIL;

      if (p == 0) seen_seq_tag = (b == SEQ_TAG);
      else if (p == 1) trk_total = b;
      else if (p == 2) seen_r_tag = (b == INT_TAG);
      else if (p == 3) trk_rlen = b;
      else begin
         if (p == 4 && r >= 1) begin
            r_is_neg = b[7];
            lead_zero = (b == 8'h00);
         end
         if (p == 5 && r > 1) r_is_padded = lead_zero && !b[7];
         if (p == 4 + r) seen_s_tag = (b == INT_TAG);
         if (p == 5 + r) begin
            trk_slen = b;
            s_cmp = (b < S_FULL_BYTES) ? CMP_LESS : (b > S_FULL_BYTES) ? CMP_GREATER : CMP_EQUAL;
         end
         if (p == 6 + r) begin
            s_is_neg = b[7];
            lead_zero = (b == 8'h00);
         end
         if (p == 7 + r && s > 1) s_is_padded = lead_zero && !b[7];
         // compare a full-length S against half order, most significant byte first
         if (s == S_FULL_BYTES && s_cmp == CMP_EQUAL && p >= 6 + r &&
             p < 6 + r + int'(S_FULL_BYTES)) begin
            h = half_byte(p - 6 - r);
            if (b < h) s_cmp = CMP_LESS;
            else if (b > h) s_cmp = CMP_GREATER;
         end
      end

      res.value = b;
      res.done = last;
      if (last) begin
         res.err = judge_signature(p + 1);
         res.ok = (res.err == ERR_OK);
         clear_tracker();
      end else begin
         res.err = ERR_OK;
         res.ok = 1'b0;
         if (trk_pos < POS_MAX) trk_pos++;
      end
      return res;
   endfunction

   task automatic note_mismatch(string what, int got, int want);
      mismatch_count++;
      // keep the log short when the block is badly off
      if (mismatch_count <= 40)
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Sender: present queued bytes in bursts, predict each accepted transaction
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      sig_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            tagged_byte_q.push_back(track_byte(req_tdata, req_tlast));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || sig_byte_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               nxt = sig_byte_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.sig_byte;
               req_tlast <= nxt.last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Receiver: check each result transaction, stall on a changing pattern
   int        stall_cycle = 0;
   stall_type stall_mode = STALL_NONE;

   always @(posedge clock) begin
      tagged_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tagged_byte_q.size() == 0) begin
               note_mismatch("result with nothing expected, value", rsp_tdata[7:0], 0);
            end else begin
               want = tagged_byte_q.pop_front();
               bytes_checked++;
               if (want.done) verdict_hits[want.err]++;
               if (rsp_tuser != want.role) note_mismatch("byte_role", rsp_tuser, want.role);
               if (rsp_tdata[7:0] != want.value)
                  note_mismatch("value", rsp_tdata[7:0], want.value);
               if (rsp_tlast != want.done) note_mismatch("done_res", rsp_tlast, want.done);
               if (rsp_tdata[8] != want.ok) note_mismatch("valid_res", rsp_tdata[8], want.ok);
               if (rsp_tdata[12:9] != want.err)
                  note_mismatch("error_code", rsp_tdata[12:9], want.err);
            end
         end
         stall_cycle++;
         if (stall_cycle % 97 == 0) stall_mode = stall_type'($urandom_range(0, 2));
         case (stall_mode)
            STALL_NONE: rsp_tready <= 1'b1;
            STALL_RANDOM: rsp_tready <= ($urandom_range(0, 2) != 0);
            default: rsp_tready <= ((stall_cycle % 11) < 4);
         endcase
      end
   end

   // Integer body: canonical DER content, S of 32 bytes often tracks half order
   task automatic append_integer(int len, bit is_s);
      int k;
      if (is_s && len == 32 && $urandom_range(0, 1) == 1) begin
         k = $urandom_range(0, 32);
         for (int i = 0; i < 32; i++) begin
            if (i < k) frame_q.push_back(half_byte(i));
            else if (i == 0) frame_q.push_back(8'($urandom_range(0, 127)));
            else frame_q.push_back(8'($urandom_range(0, 255)));
         end
      end else if (len > 1 && $urandom_range(0, 3) == 0) begin
         frame_q.push_back(8'h00);
         frame_q.push_back(8'($urandom_range(128, 255)));
         for (int i = 2; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         frame_q.push_back(8'($urandom_range(len > 1 ? 1 : 0, 127)));
         for (int i = 1; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   function automatic int pick_length();
      return ($urandom_range(0, 9) < 3) ? $urandom_range(32, 33) : $urandom_range(1, 20);
   endfunction

   task automatic build_frame();
      int r;
      int s;
      r = pick_length();
      s = pick_length();
      frame_q.delete();
      frame_q.push_back(SEQ_TAG);
      frame_q.push_back(8'(4 + r + s));
      frame_q.push_back(INT_TAG);
      frame_q.push_back(8'(r));
      append_integer(r, 1'b0);
      frame_q.push_back(INT_TAG);
      frame_q.push_back(8'(s));
      append_integer(s, 1'b1);
   endtask

   // Break one rule of a freshly built signature
   task automatic apply_flaw(flaw_type f);
      int r;
      int s;
      int k;
      r = frame_q[3];
      s = frame_q[5 + r];
      case (f)
         FLAW_SEQ_TAG: frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
         FLAW_TOTAL_LEN: begin
            k = $urandom_range(0, 2);
            if (k == 0) frame_q[1] = frame_q[1] + 8'd1;
            else if (k == 1) frame_q[1] = frame_q[1] - 8'd1;
            else frame_q[1] = 8'($urandom_range(0, 255));
         end
         FLAW_R_TAG: frame_q[2] = frame_q[2] ^ 8'($urandom_range(1, 255));
         FLAW_R_LEN: frame_q[3] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255));
         FLAW_R_NEG: frame_q[4] = frame_q[4] | 8'h80;
         FLAW_R_PAD: begin
            if (r > 1) begin
               frame_q[4] = 8'h00;
               frame_q[5] = frame_q[5] & 8'h7F;
            end
         end
         FLAW_S_TAG: frame_q[4 + r] = frame_q[4 + r] ^ 8'($urandom_range(1, 255));
         FLAW_S_LEN: begin
            if ($urandom_range(0, 1) == 1) frame_q[5 + r] = 8'($urandom_range(0, 255));
            else frame_q[5 + r] = frame_q[5 + r] + 8'd1;
         end
         FLAW_S_NEG: frame_q[6 + r] = frame_q[6 + r] | 8'h80;
         FLAW_S_PAD: begin
            if (s > 1) begin
               frame_q[6 + r] = 8'h00;
               frame_q[7 + r] = frame_q[7 + r] & 8'h7F;
            end
         end
         FLAW_TRAILING: repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
         FLAW_TRUNCATE: begin
            repeat ($urandom_range(1, 6))
               if (frame_q.size() > 1) frame_q.delete(frame_q.size() - 1);
         end
         FLAW_HIGH_S: begin
            // match half order on a prefix, then exceed it by a little
            if (s == 32) begin
               k = $urandom_range(16, 31);
               for (int i = 0; i < k; i++) frame_q[6 + r + i] = half_byte(i);
               frame_q[6 + r + k] = 8'($urandom_range(int'(half_byte(k)) + 1, 255));
            end
         end
         default: ;
      endcase
   endtask

   task automatic random_frame(int lo, int hi);
      int n;
      n = $urandom_range(lo, hi);
      frame_q.delete();
      repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) frame_q[0] = SEQ_TAG;
   endtask

   task automatic push_frame();
      sig_item_type it;
      foreach (frame_q[i]) begin
         it.sig_byte = frame_q[i];
         it.last = (i == frame_q.size() - 1);
         sig_byte_q.push_back(it);
      end
      queued_bytes += frame_q.size();
   endtask

   // Queue whole signatures until about n more bytes are pending
   task automatic fill_phase(int n);
      int goal;
      int pick;
      goal = queued_bytes + n;
      while (queued_bytes < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            build_frame();
         end else if (pick < 85) begin
            build_frame();
            apply_flaw(flaw_type'($urandom_range(0, FLAW_COUNT - 1)));
         end else if (pick < 92) begin
            random_frame(1, 9);
         end else if (pick < 96) begin
            random_frame(73, 140);
         end else begin
            random_frame(8, 72);
         end
         push_frame();
      end
   endtask

   task automatic wait_until_idle();
      @(negedge clock);
      while (sig_byte_q.size() != 0 || req_tvalid || tagged_byte_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_config(logic strict, logic low_s);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_DER_EXACT;
      csr_wdata <= strict;
      @(posedge clock);
      csr_addr <= CSR_REQUIRE_LOW_S;
      csr_wdata <= low_s;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_strict = strict;
      cfg_low_s = low_s;
   endtask

   // Stimulus: directed signatures, then random phases under each setting
   initial begin
      int codes_seen;
      logic [1:0] settings[4];
      settings = '{2'b01, 2'b10, 2'b00, 2'b11};
      clear_tracker();
      foreach (verdict_hits[i]) verdict_hits[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // smallest valid signature, a one-byte buffer, a padded S
      frame_q = '{SEQ_TAG, 8'h06, INT_TAG, 8'h01, 8'h7F, INT_TAG, 8'h01, 8'h00};
      push_frame();
      frame_q = '{8'hFF};
      push_frame();
      frame_q = '{SEQ_TAG, 8'h07, INT_TAG, 8'h01, 8'h00, INT_TAG, 8'h02, 8'h00, 8'h80};
      push_frame();
      fill_phase(226);
      wait_until_idle();

      foreach (settings[i]) begin
         repeat (4) @(posedge clock);
         set_config(settings[i][1], settings[i][0]);
         @(negedge clock);
         fill_phase(226);
         wait_until_idle();
      end

      repeat (8) @(posedge clock);
      if (tagged_byte_q.size() != 0)
         note_mismatch("results never delivered", 0, tagged_byte_q.size());

      codes_seen = 0;
      for (int c = 0; c <= int'(ERR_HIGH_S); c++)
         if (verdict_hits[c] > 0) codes_seen++;
      $display("summary: %0d bytes checked in 5 phases over all 4 register settings",
               bytes_checked);
      $display("summary: %0d of 13 verdict codes produced", codes_seen);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #4_800_000;
      $display("tb: failure");
      $finish;
   end

endmodule
